### rtl/wrf_pkg.sv
// ----------------------------------------------------------------------------
// wrf_pkg
// Shared types and constants of the window rank filter.
// ----------------------------------------------------------------------------
package wrf_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_RADIUS = 7;
    localparam int PIXEL_BITS = 16;

    localparam int COORD_BITS = 8;
    localparam int SIZE_BITS  = 9;
    localparam int RAD_BITS   = 3;
    localparam int MODE_BITS  = 2;
    localparam int CNT_BITS   = 8;
    localparam int POS_BITS   = 10;     // signed window coordinate
    localparam int BIT_BITS   = 4;      // index of a pixel bit
    localparam int WIN_MAX    = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int STORE_BITS = 2 * COORD_BITS;

    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 9;

    localparam logic [CFG_ADDR_BITS-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_RADIUS = 2'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MODE   = 2'd3;

    localparam logic [MODE_BITS-1:0] MODE_MEDIAN = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_MIN    = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_MAX    = 2'd2;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_FILTER = 1'b1;

    localparam int IN_DATA_BITS  = 32;
    localparam int OUT_DATA_BITS = 24;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GATHER,
        ST_DRAIN,
        ST_PREP,
        ST_SEL,
        ST_SEL_END,
        ST_DONE
    } t_state;

endpackage

### rtl/window_rank_filter.sv
// ----------------------------------------------------------------------------
// window_rank_filter
// Frame store with a square-window median / minimum / maximum filter.
// ----------------------------------------------------------------------------
// Input channel (s): tuser = kind, tdata = col, row, pixel_in. A load item
// writes one pixel in its accept cycle and the block stays ready. A filter item
// collects the window pixels from the single frame store port (one read per
// cycle over all (2r+1)^2 positions), then runs a bit-serial rank selection:
// 16 passes over the collected pixels, one buffer read per cycle, both middle
// ranks tracked in the same pass. The block is not ready while a filter item
// is in progress. An item outside the image goes straight to the done state.
// Output channel (m): tdata = filtered, window_count; tuser = bad_coord. The
// result sits in an output register; the next item is taken while it waits,
// and a later filter result holds in the done state until the register frees.
// Reset sets the registers to 256x256, radius 1, median, and empties the
// output. The frame store is not cleared: read only pixels that were loaded.
// Config writes (i_cfg_we) are to be made while the block is idle.
// ----------------------------------------------------------------------------
module window_rank_filter (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [wrf_pkg::CFG_ADDR_BITS-1:0]      i_cfg_addr,
    input  logic [wrf_pkg::CFG_DATA_BITS-1:0]      i_cfg_data,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    input  logic [wrf_pkg::IN_DATA_BITS-1:0]       i_s_tdata,  // col, row, pixel_in
    input  logic                                   i_s_tuser,  // kind
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    output logic [wrf_pkg::OUT_DATA_BITS-1:0]      o_m_tdata,  // filtered, window_count
    output logic                                   o_m_tuser   // bad_coord
);

    localparam int PB = wrf_pkg::PIXEL_BITS;
    localparam int CB = wrf_pkg::CNT_BITS;
    localparam int QB = wrf_pkg::POS_BITS;

    wrf_pkg::t_state r_state, n_state;

    logic [wrf_pkg::SIZE_BITS-1:0] r_width, r_height;
    logic [wrf_pkg::RAD_BITS-1:0]  r_radius;
    logic [wrf_pkg::MODE_BITS-1:0] r_mode;

    logic [PB-1:0] r_store [0:(1 << wrf_pkg::STORE_BITS)-1];
    logic [PB-1:0] r_fs_q;
    logic [PB-1:0] r_wbuf [0:wrf_pkg::WIN_MAX-1];
    logic [PB-1:0] r_wb_q;

    logic signed [QB-1:0] r_x, r_y, r_xe, r_ys, r_ye;
    logic          r_pend, r_rv;
    logic [CB-1:0] r_cnt, r_j, r_ka, r_kb, r_ca, r_cb;
    logic [PB-1:0] r_pa, r_pb;
    logic [wrf_pkg::BIT_BITS-1:0] r_bit;
    logic          r_bad;
    logic          r_out_valid, r_out_bad;
    logic [PB-1:0] r_out_val;
    logic [CB-1:0] r_out_cnt;

    logic [wrf_pkg::SIZE_BITS-1:0] eff_w, eff_h;
    logic [wrf_pkg::COORD_BITS-1:0] in_col, in_row;
    logic [PB-1:0] in_pix;
    logic          accept, in_image, in_bounds, scan_last, sel_last, out_free;
    logic          hit_a, hit_b;
    logic [PB-1:0] hi_mask;
    logic [CB-1:0] ca_tot, cb_tot, half;
    logic [PB:0]   res_sum;
    logic signed [QB-1:0] radius_s;

    assign in_col = i_s_tdata[7:0];
    assign in_row = i_s_tdata[15:8];
    assign in_pix = i_s_tdata[31:16];

    assign eff_w = (r_width  > wrf_pkg::SIZE_BITS'(wrf_pkg::MAX_WIDTH))
                 ? wrf_pkg::SIZE_BITS'(wrf_pkg::MAX_WIDTH)  : r_width;
    assign eff_h = (r_height > wrf_pkg::SIZE_BITS'(wrf_pkg::MAX_HEIGHT))
                 ? wrf_pkg::SIZE_BITS'(wrf_pkg::MAX_HEIGHT) : r_height;

    assign accept   = i_s_tvalid && o_s_tready;
    assign in_image = ({1'b0, in_col} < eff_w) && ({1'b0, in_row} < eff_h);
    assign radius_s = $signed({{(QB-wrf_pkg::RAD_BITS){1'b0}}, r_radius});
    assign out_free = !r_out_valid || i_m_tready;

    assign in_bounds = (r_x >= 0) && (r_x < $signed({1'b0, eff_w}))
                    && (r_y >= 0) && (r_y < $signed({1'b0, eff_h}));
    assign scan_last = (r_x == r_xe) && (r_y == r_ye);
    assign sel_last  = (r_j == r_cnt - 1'b1);

    // bits above the one under test
    assign hi_mask = ({PB{1'b1}} << r_bit) << 1;
    assign hit_a   = r_rv && (((r_wb_q ^ r_pa) & hi_mask) == '0) && !r_wb_q[r_bit];
    assign hit_b   = r_rv && (((r_wb_q ^ r_pb) & hi_mask) == '0) && !r_wb_q[r_bit];
    assign ca_tot  = r_ca + CB'(hit_a);
    assign cb_tot  = r_cb + CB'(hit_b);
    assign half    = r_cnt >> 1;
    assign res_sum = {1'b0, r_pa} + {1'b0, r_pb};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wrf_pkg::ST_IDLE: begin
                if (accept && i_s_tuser == wrf_pkg::KIND_FILTER) begin
                    n_state = in_image ? wrf_pkg::ST_GATHER : wrf_pkg::ST_DONE;
                end
            end
            wrf_pkg::ST_GATHER:  if (scan_last) n_state = wrf_pkg::ST_DRAIN;
            wrf_pkg::ST_DRAIN:   n_state = wrf_pkg::ST_PREP;
            wrf_pkg::ST_PREP:    n_state = wrf_pkg::ST_SEL;
            wrf_pkg::ST_SEL:     if (sel_last) n_state = wrf_pkg::ST_SEL_END;
            wrf_pkg::ST_SEL_END: begin
                n_state = (r_bit == '0) ? wrf_pkg::ST_DONE : wrf_pkg::ST_SEL;
            end
            wrf_pkg::ST_DONE:    if (out_free) n_state = wrf_pkg::ST_IDLE;
            default:             n_state = wrf_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_s_tready = (r_state == wrf_pkg::ST_IDLE);
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_cnt, r_out_val};
    assign o_m_tuser  = r_out_bad;

    // frame store: one port, loads write, gather reads
    always_ff @(posedge i_clk) begin
        if (accept && i_s_tuser == wrf_pkg::KIND_LOAD && in_image) begin
            r_store[{in_row, in_col}] <= in_pix;
        end
        r_fs_q <= r_store[{r_y[7:0], r_x[7:0]}];
    end

    // window buffer
    always_ff @(posedge i_clk) begin
        if (r_pend) begin
            r_wbuf[r_cnt] <= r_fs_q;
        end
        r_wb_q <= r_wbuf[r_j];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wrf_pkg::ST_IDLE;
            r_width     <= wrf_pkg::SIZE_BITS'(wrf_pkg::MAX_WIDTH);
            r_height    <= wrf_pkg::SIZE_BITS'(wrf_pkg::MAX_HEIGHT);
            r_radius    <= wrf_pkg::RAD_BITS'(1);
            r_mode      <= wrf_pkg::MODE_MEDIAN;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_rv        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    wrf_pkg::CFG_WIDTH:  r_width  <= i_cfg_data;
                    wrf_pkg::CFG_HEIGHT: r_height <= i_cfg_data;
                    wrf_pkg::CFG_RADIUS: r_radius <= i_cfg_data[wrf_pkg::RAD_BITS-1:0];
                    wrf_pkg::CFG_MODE:   r_mode   <= i_cfg_data[wrf_pkg::MODE_BITS-1:0];
                    default: ;
                endcase
            end
            r_out_valid <= (r_state == wrf_pkg::ST_DONE && out_free)
                        || (r_out_valid && !i_m_tready);
            r_pend <= (r_state == wrf_pkg::ST_GATHER) && in_bounds;
            r_rv   <= (r_state == wrf_pkg::ST_SEL);
            if (r_pend) r_cnt <= r_cnt + 1'b1;

            unique case (r_state)
                wrf_pkg::ST_IDLE: begin
                    r_cnt <= '0;
                    r_pa  <= '0;
                    r_pb  <= '0;
                    r_bad <= !in_image;
                    r_x   <= $signed({2'b00, in_col}) - radius_s;
                    r_xe  <= $signed({2'b00, in_col}) + radius_s;
                    r_y   <= $signed({2'b00, in_row}) - radius_s;
                    r_ys  <= $signed({2'b00, in_row}) - radius_s;
                    r_ye  <= $signed({2'b00, in_row}) + radius_s;
                end
                wrf_pkg::ST_GATHER: begin
                    if (r_y == r_ye) begin
                        r_y <= r_ys;
                        r_x <= r_x + 1'b1;
                    end else begin
                        r_y <= r_y + 1'b1;
                    end
                end
                wrf_pkg::ST_DRAIN: ;
                wrf_pkg::ST_PREP: begin
                    r_bit <= wrf_pkg::BIT_BITS'(PB - 1);
                    r_j   <= '0;
                    r_ca  <= '0;
                    r_cb  <= '0;
                    priority if (r_mode == wrf_pkg::MODE_MIN) begin
                        r_ka <= '0;
                        r_kb <= '0;
                    end else if (r_mode == wrf_pkg::MODE_MAX) begin
                        r_ka <= r_cnt - 1'b1;
                        r_kb <= r_cnt - 1'b1;
                    end else if (!r_cnt[0]) begin
                        r_ka <= half - 1'b1;
                        r_kb <= half;
                    end else begin
                        r_ka <= half;
                        r_kb <= half;
                    end
                end
                wrf_pkg::ST_SEL: begin
                    r_j  <= r_j + 1'b1;
                    r_ca <= ca_tot;
                    r_cb <= cb_tot;
                end
                wrf_pkg::ST_SEL_END: begin
                    if (r_ka < ca_tot) begin
                        r_pa[r_bit] <= 1'b0;
                    end else begin
                        r_pa[r_bit] <= 1'b1;
                        r_ka <= r_ka - ca_tot;
                    end
                    if (r_kb < cb_tot) begin
                        r_pb[r_bit] <= 1'b0;
                    end else begin
                        r_pb[r_bit] <= 1'b1;
                        r_kb <= r_kb - cb_tot;
                    end
                    r_bit <= r_bit - 1'b1;
                    r_j   <= '0;
                    r_ca  <= '0;
                    r_cb  <= '0;
                end
                wrf_pkg::ST_DONE: begin
                    if (out_free) begin
                        r_out_val   <= res_sum[PB:1];
                        r_out_cnt   <= r_cnt;
                        r_out_bad   <= r_bad;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

### rtl/wrf_checker.sv
// ----------------------------------------------------------------------------
// wrf_checker
// Port-level checks of the window rank filter, bound to the top level.
// ----------------------------------------------------------------------------
module wrf_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_s_tvalid,
    input logic                                  o_s_tready,
    input logic                                  i_s_tuser,
    input logic                                  o_m_tvalid,
    input logic                                  i_m_tready,
    input logic [wrf_pkg::OUT_DATA_BITS-1:0]     o_m_tdata,
    input logic                                  o_m_tuser
);

    // a filter item leaves the block not ready in the cycle after its acceptance
    a_busy_after_filter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser == wrf_pkg::KIND_FILTER) |=> !o_s_tready)
        else $error("ready right after a filter item");

    a_bad_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == '0))
        else $error("out-of-image result not zero");

    // centre pixel always counts
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata[23:16] != '0))
        else $error("in-image result with empty window");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

endmodule

bind window_rank_filter wrf_checker u_wrf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
